/* hdl/wat_pkg.sv */
// wat_pkg: types and constants shared by the weekly alarm table modules.
// No dependencies.
`timescale 1ns / 1ps

package wat_pkg;

  localparam int MAX_ENTRIES  = 16;
  localparam int IDX_W        = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
  localparam int RESULT_LIMIT = 16;
  localparam int NRES_W       = $clog2(RESULT_LIMIT + 1);
  localparam int QDEPTH       = 2;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FIRED     = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  task_id;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
    logic [6:0]  day_mask;
    logic        enabled;
    logic        executed;
    logic [15:0] action_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  task_id_res;
    logic [4:0]  entry_hour;
    logic [5:0]  entry_minute;
    logic [6:0]  entry_mask;
    logic        entry_enabled;
    logic        entry_executed;
    logic [15:0] entry_tag;
    logic [4:0]  entry_count;
    logic        changed;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [6:0]  mask;
    logic        enabled;
    logic        executed;
    logic [15:0] tag;
  } entry_t;

  // classified request handed from front to back
  typedef struct packed {
    in_item_t    item;
    logic        id_zero;
    logic        is_tick;
    logic        is_search;
    logic        known;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINAL
  } back_state_e;

endpackage

/* hdl/wat_front.sv */
// wat_front: accepts requests, classifies them and queues them for the back end.
// Depends on wat_pkg.
`timescale 1ns / 1ps

module wat_front import wat_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t in_item,
  input  logic     in_push,
  output logic     in_full,
  output req_t     q_req,
  output logic     q_valid,
  input  logic     q_take
);

  localparam int QP_W = $clog2(QDEPTH);

  req_t              q_mem [QDEPTH];
  logic [QP_W-1:0]   wp_r, rp_r;
  logic [QP_W:0]     cnt_r;
  req_t              cls;
  logic              wr, rd;

  always_comb begin
    cls.item      = in_item;
    cls.id_zero   = (in_item.task_id == 8'd0);
    cls.is_tick   = (in_item.cmd == CMD_TICK);
    cls.is_search = (in_item.cmd == CMD_REMOVE) || (in_item.cmd == CMD_REPLACE) ||
                    (in_item.cmd == CMD_READ);
    cls.known     = (in_item.cmd <= CMD_READ);
  end

  assign in_full = (cnt_r == (QP_W+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_req   = q_mem[rp_r];
  assign wr      = in_push && !in_full;
  assign rd      = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr) q_mem[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QP_W+1)'(wr) - (QP_W+1)'(rd);
    end
  end

endmodule

/* hdl/wat_back.sv */
// wat_back: walks the entry table one entry a cycle unless the output stalls; makes results.
// Depends on wat_pkg.
`timescale 1ns / 1ps

module wat_back import wat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  req_t      q_req,
  input  logic      q_valid,
  output logic      q_take,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

  back_state_e       state_r, state_nxt;
  req_t              req_r, req_nxt;
  entry_t            tbl [MAX_ENTRIES];
  entry_t            cur_r;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  rd_idx;
  logic [NRES_W-1:0] nres_r, nres_nxt;
  logic              chg_r, chg_nxt;
  logic              found_r, found_nxt;
  out_item_t         res_r, res_nxt;
  logic              full_r, full_nxt;
  entry_t            ent_r, ent_nxt;
  entry_t            wdata;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [7:0]        day_bits;
  logic              hit, in_day, tmatch, fires, clears, wait_out;

  function automatic out_item_t fire_res(entry_t e, logic [CNT_W-1:0] cnt, logic chg,
                                         logic lst);
    out_item_t r;
    r = '{status: ST_FIRED, task_id_res: e.id, entry_hour: e.hour,
          entry_minute: e.minute, entry_mask: e.mask,
          entry_enabled: e.enabled, entry_executed: e.executed,
          entry_tag: e.tag, entry_count: 5'(cnt),
          changed: chg, last: lst};
    return r;
  endfunction

  // weekday seven falls on the zero pad bit and matches nothing
  assign day_bits = {1'b0, cur_r.mask};
  assign in_day   = cur_r.enabled && day_bits[req_r.item.weekday];
  assign tmatch   = (cur_r.hour == req_r.item.hour) && (cur_r.minute == req_r.item.minute);
  assign hit      = (cur_r.id == req_r.item.task_id);
  assign fires    = in_day && tmatch && !cur_r.executed;
  assign clears   = in_day && !tmatch && cur_r.executed;

  assign out_item  = res_r;
  assign out_empty = !full_r;

  always_ff @(posedge clk) begin
    if (we) tbl[waddr] <= wdata;
    cur_r <= tbl[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      full_r  <= full_nxt;
    end
    req_r   <= req_nxt;
    idx_r   <= idx_nxt;
    nres_r  <= nres_nxt;
    chg_r   <= chg_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
    ent_r   <= ent_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    nres_nxt  = nres_r;
    chg_nxt   = chg_r;
    found_nxt = found_r;
    res_nxt   = res_r;
    ent_nxt   = ent_r;
    full_nxt  = full_r && !out_pop;
    q_take    = 1'b0;
    we        = 1'b0;
    waddr     = idx_r[IDX_W-1:0];
    wdata     = cur_r;
    // a new fire pushes the held one out, which needs a free output register
    wait_out  = fires && (nres_r != '0) && (nres_r < NRES_W'(RESULT_LIMIT)) && full_nxt;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_take    = 1'b1;
          req_nxt   = q_req;
          idx_nxt   = '0;
          nres_nxt  = '0;
          chg_nxt   = 1'b0;
          found_nxt = 1'b0;
          if (q_req.is_tick || (q_req.is_search && !q_req.id_zero)) state_nxt = S_SCAN;
          else state_nxt = S_FINAL;
        end
      end
      S_SCAN: begin
        if (idx_r >= total_r) begin
          state_nxt = S_FINAL;
        end else if (req_r.is_tick) begin
          if (!wait_out) begin
            idx_nxt = idx_r + 1'b1;
            if (fires) begin
              we             = 1'b1;
              wdata.executed = 1'b1;
              chg_nxt        = 1'b1;
              if (nres_r < NRES_W'(RESULT_LIMIT)) begin
                // the newest fire is held in ent_r so the final one can carry last
                if (nres_r != '0) begin
                  res_nxt  = fire_res(ent_r, total_r, 1'b0, 1'b0);
                  full_nxt = 1'b1;
                end
                nres_nxt         = nres_r + 1'b1;
                ent_nxt          = cur_r;
                ent_nxt.executed = 1'b1;
              end
            end else if (clears) begin
              we             = 1'b1;
              wdata.executed = 1'b0;
              chg_nxt        = 1'b1;
            end
          end
        end else if (hit) begin
          found_nxt = 1'b1;
          ent_nxt   = cur_r;
          state_nxt = (req_r.item.cmd == CMD_REMOVE) ? S_SHIFT : S_FINAL;
          if (req_r.item.cmd == CMD_REPLACE) begin
            we    = 1'b1;
            wdata = '{id: cur_r.id, hour: req_r.item.hour, minute: req_r.item.minute,
                      mask: req_r.item.day_mask, enabled: req_r.item.enabled,
                      executed: req_r.item.executed, tag: req_r.item.action_tag};
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SHIFT: begin
        // cur_r holds the entry just above idx_r
        if (idx_r + 1'b1 < total_r) begin
          we      = 1'b1;
          wdata   = cur_r;
          idx_nxt = idx_r + 1'b1;
        end else begin
          total_nxt = total_r - 1'b1;
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (!full_nxt) begin
          res_nxt = '0;
          res_nxt.last = 1'b1;
          res_nxt.status = ST_OK;
          if (req_r.is_tick) begin
            if (nres_r == '0) begin
              res_nxt.status  = ST_NONE;
              res_nxt.changed = chg_r;
            end else begin
              res_nxt = fire_res(ent_r, total_r, chg_r, 1'b1);
            end
          end else if (!req_r.known) begin
            res_nxt.status = ST_OK;
          end else if (req_r.item.cmd == CMD_ADD) begin
            if (req_r.id_zero) res_nxt.status = ST_NOT_FOUND;
            else if (total_r >= CNT_W'(MAX_ENTRIES)) res_nxt.status = ST_FULL;
            else begin
              we        = 1'b1;
              waddr     = total_r[IDX_W-1:0];
              wdata     = '{id: req_r.item.task_id, hour: req_r.item.hour,
                            minute: req_r.item.minute, mask: req_r.item.day_mask,
                            enabled: req_r.item.enabled, executed: req_r.item.executed,
                            tag: req_r.item.action_tag};
              total_nxt = total_r + 1'b1;
            end
          end else if (!found_r) begin
            res_nxt.status = ST_NOT_FOUND;
          end else if (req_r.item.cmd == CMD_READ) begin
            res_nxt.task_id_res    = ent_r.id;
            res_nxt.entry_hour     = ent_r.hour;
            res_nxt.entry_minute   = ent_r.minute;
            res_nxt.entry_mask     = ent_r.mask;
            res_nxt.entry_enabled  = ent_r.enabled;
            res_nxt.entry_executed = ent_r.executed;
            res_nxt.entry_tag      = ent_r.tag;
          end
          res_nxt.entry_count = 5'(total_nxt);
          full_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // table read is registered: fetch the entry needed next cycle
    rd_idx = idx_nxt + CNT_W'(state_nxt == S_SHIFT);
    raddr  = rd_idx[IDX_W-1:0];
  end

endmodule

/* hdl/weekly_alarm_table.sv */
// weekly_alarm_table: top level, front classifier, request queue and table walker.
// Depends on wat_pkg, wat_front, wat_back.
//
//   channel  direction  handshake     payload
//   in_      request    push / full   in_item_t
//   out_     result     pop / empty   out_item_t
//
// A request waits in a two-deep queue. The walker takes it from the queue, visits
// one entry per cycle, then checks past the end of the table and writes the final
// result; a hit ends the search, remove then shifts the entries above it down,
// and add and unknown commands go straight to the final result. Results wait in
// one output register; a result push that finds it occupied stalls the walker.
// Reset (rst_n low, synchronous) empties the table, the queue and the register.
`timescale 1ns / 1ps

module weekly_alarm_table import wat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      in_push,
  output logic      in_full,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

  req_t q_req;
  logic q_valid, q_take;

  wat_front u_front (
    .clk, .rst_n, .in_item, .in_push, .in_full,
    .q_req, .q_valid, .q_take
  );

  wat_back u_back (
    .clk, .rst_n, .q_req, .q_valid, .q_take,
    .out_item, .out_empty, .out_pop
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.entry_count <= 5'(MAX_ENTRIES))
    else $error("entry count above table size");
  a_changed_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.changed) |-> out_item.last)
    else $error("changed set on a non-final result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("stalled result changed");
`endif

endmodule
